// ===== src/hsv2rgb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// shared constants, sector codes and stage payload types for the hsv to rgb
// pixel pipeline
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    // number formats
    localparam int unsigned HUE_FRAC_BITS     = 6;
    localparam int unsigned CHANNEL_FRAC_BITS = 16;

    localparam int unsigned HUE_W = 16;        // signed hue field
    localparam int unsigned H_W   = HUE_W - 1; // magnitude of a legal hue
    localparam int unsigned CH_W  = 17;        // channel fields

    localparam longint unsigned ONE        = 64'd1 << CHANNEL_FRAC_BITS;
    localparam longint unsigned HALF_ONE   = ONE / 2;
    localparam longint unsigned SECT_SIZE  = 64'd60 << HUE_FRAC_BITS;
    localparam longint unsigned FULL_TURN  = 64'd360 << HUE_FRAC_BITS;
    localparam int unsigned     REM_W      = $clog2(SECT_SIZE);

    // common denominator one * sector size = 15 * 2^DEN_SHIFT
    localparam longint unsigned DEN        = SECT_SIZE * ONE;
    localparam longint unsigned HALF_DEN   = DEN / 2;
    localparam int unsigned     DEN_SHIFT  = HUE_FRAC_BITS + 2 + CHANNEL_FRAC_BITS;
    localparam int unsigned     DEN_W      = $clog2(DEN + 1);

    // product widths
    localparam int unsigned SR_W = CH_W + REM_W;  // s * r
    localparam int unsigned PN_W = 2 * CH_W;      // v * (one - s)
    localparam int unsigned QN_W = CH_W + DEN_W;  // v * (den - s * r)
    localparam int unsigned QX_W = QN_W - DEN_SHIFT;

    // division by 15 through a reciprocal, exact for every QX_W-bit value
    localparam int unsigned     RECIP_SHIFT = QX_W + 4;
    localparam longint unsigned RECIP       = ((64'd1 << RECIP_SHIFT) + 64'd14) / 64'd15;
    localparam int unsigned     RECIP_W     = RECIP_SHIFT - 3;
    localparam int unsigned     PR_W        = QX_W + RECIP_W;

    // hue sectors of 60 degrees
    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } t_sector;

    // after decode
    typedef struct packed {
        logic             err;
        logic             grey;
        t_sector          sector;
        logic [REM_W-1:0] rem;
        logic [CH_W-1:0]  sat;
        logic [CH_W-1:0]  val;
    } t_dec;

    // after the wide products
    typedef struct packed {
        logic            err;
        logic            grey;
        t_sector         sector;
        logic [CH_W-1:0] val;
        logic [PN_W-1:0] p_num;
        logic [QN_W-1:0] q_num;
        logic [QN_W-1:0] t_num;
    } t_prod;

    // after rounding
    typedef struct packed {
        logic            err;
        logic            grey;
        t_sector         sector;
        logic [CH_W-1:0] val;
        logic [CH_W-1:0] p_val;
        logic [QX_W-1:0] q_x;
        logic [QX_W-1:0] t_x;
    } t_rnd;

endpackage

// ===== src/hsv2rgb_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_decode
// range check, full-turn wrap, sector split and remainder (one stage)
// ----------------------------------------------------------------------------
module hsv2rgb_decode (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_up_valid,
    output logic                            o_up_stall,
    input  logic [hsv2rgb_pkg::HUE_W-1:0]   i_hue,
    input  logic [hsv2rgb_pkg::CH_W-1:0]    i_saturation,
    input  logic [hsv2rgb_pkg::CH_W-1:0]    i_brightness,
    output logic                            o_dn_valid,
    input  logic                            i_dn_stall,
    output hsv2rgb_pkg::t_dec               o_dec
);
    import hsv2rgb_pkg::*;

    logic         r_vld;
    t_dec         r_dec;
    t_dec         n_dec;
    logic         w_hold;
    logic [H_W-1:0] w_h;
    logic [H_W-1:0] w_base;
    t_sector      w_sector;

    assign w_hold = r_vld && i_dn_stall;

    always_comb begin
        // a hue of a full turn is the same as zero
        w_h = (i_hue[H_W-1:0] == H_W'(FULL_TURN)) ? '0 : i_hue[H_W-1:0];

        priority if (w_h >= H_W'(5 * SECT_SIZE)) begin
            w_sector = SEC_MAG_RED;
            w_base   = H_W'(5 * SECT_SIZE);
        end else if (w_h >= H_W'(4 * SECT_SIZE)) begin
            w_sector = SEC_BLU_MAG;
            w_base   = H_W'(4 * SECT_SIZE);
        end else if (w_h >= H_W'(3 * SECT_SIZE)) begin
            w_sector = SEC_CYN_BLU;
            w_base   = H_W'(3 * SECT_SIZE);
        end else if (w_h >= H_W'(2 * SECT_SIZE)) begin
            w_sector = SEC_GRN_CYN;
            w_base   = H_W'(2 * SECT_SIZE);
        end else if (w_h >= H_W'(SECT_SIZE)) begin
            w_sector = SEC_YEL_GRN;
            w_base   = H_W'(SECT_SIZE);
        end else begin
            w_sector = SEC_RED_YEL;
            w_base   = '0;
        end

        n_dec.err    = i_hue[HUE_W-1]
                    || (i_hue[H_W-1:0] > H_W'(FULL_TURN))
                    || (i_saturation > CH_W'(ONE))
                    || (i_brightness > CH_W'(ONE));
        n_dec.grey   = (i_saturation == '0);
        n_dec.sector = w_sector;
        n_dec.rem    = REM_W'(w_h - w_base);
        n_dec.sat    = i_saturation;
        n_dec.val    = i_brightness;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (!w_hold) begin
            r_vld <= i_up_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_hold && i_up_valid) begin
            r_dec <= n_dec;
        end
    end

    assign o_up_stall = w_hold;
    assign o_dn_valid = r_vld;
    assign o_dec      = r_dec;

endmodule

// ===== src/hsv2rgb_product.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_product
// saturation by hue fraction, then brightness by the complements (two stages)
// ----------------------------------------------------------------------------
module hsv2rgb_product (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_up_valid,
    output logic                o_up_stall,
    input  hsv2rgb_pkg::t_dec   i_dec,
    output logic                o_dn_valid,
    input  logic                i_dn_stall,
    output hsv2rgb_pkg::t_prod  o_prod
);
    import hsv2rgb_pkg::*;

    typedef struct packed {
        logic            err;
        logic            grey;
        t_sector         sector;
        logic [CH_W-1:0] val;
        logic [CH_W-1:0] omsat;
        logic [SR_W-1:0] sr;
        logic [SR_W-1:0] sdr;
    } t_frac;

    logic              r_s2_vld;
    logic              r_s3_vld;
    t_frac             r_s2;
    t_frac             n_s2;
    t_prod             r_s3;
    t_prod             n_s3;
    logic              w_s2_hold;
    logic              w_s3_hold;
    logic [REM_W-1:0]  w_drem;
    logic [DEN_W-1:0]  w_q_fac;
    logic [DEN_W-1:0]  w_t_fac;

    assign w_s3_hold = r_s3_vld && i_dn_stall;
    assign w_s2_hold = r_s2_vld && w_s3_hold;

    // stage 2: s*r and s*(d-r)
    always_comb begin
        w_drem      = REM_W'(SECT_SIZE) - i_dec.rem;
        n_s2.err    = i_dec.err;
        n_s2.grey   = i_dec.grey;
        n_s2.sector = i_dec.sector;
        n_s2.val    = i_dec.val;
        n_s2.omsat  = CH_W'(ONE) - i_dec.sat;
        n_s2.sr     = SR_W'(i_dec.sat) * SR_W'(i_dec.rem);
        n_s2.sdr    = SR_W'(i_dec.sat) * SR_W'(w_drem);
    end

    // stage 3: v*(one-s), v*(den-s*r), v*(den-s*(d-r))
    always_comb begin
        w_q_fac     = DEN_W'(DEN) - DEN_W'(r_s2.sr);
        w_t_fac     = DEN_W'(DEN) - DEN_W'(r_s2.sdr);
        n_s3.err    = r_s2.err;
        n_s3.grey   = r_s2.grey;
        n_s3.sector = r_s2.sector;
        n_s3.val    = r_s2.val;
        n_s3.p_num  = PN_W'(r_s2.val) * PN_W'(r_s2.omsat);
        n_s3.q_num  = QN_W'(r_s2.val) * QN_W'(w_q_fac);
        n_s3.t_num  = QN_W'(r_s2.val) * QN_W'(w_t_fac);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            if (!w_s2_hold) begin
                r_s2_vld <= i_up_valid;
            end
            if (!w_s3_hold) begin
                r_s3_vld <= r_s2_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_s2_hold && i_up_valid) begin
            r_s2 <= n_s2;
        end
        if (!w_s3_hold && r_s2_vld) begin
            r_s3 <= n_s3;
        end
    end

    assign o_up_stall = w_s2_hold;
    assign o_dn_valid = r_s3_vld;
    assign o_prod     = r_s3;

endmodule

// ===== src/hsv2rgb_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_round
// round to nearest and strip the power-of-two part of the denominator
// ----------------------------------------------------------------------------
module hsv2rgb_round (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_up_valid,
    output logic                o_up_stall,
    input  hsv2rgb_pkg::t_prod  i_prod,
    output logic                o_dn_valid,
    input  logic                i_dn_stall,
    output hsv2rgb_pkg::t_rnd   o_rnd
);
    import hsv2rgb_pkg::*;

    logic            r_vld;
    t_rnd            r_rnd;
    t_rnd            n_rnd;
    logic            w_hold;
    logic [PN_W-1:0] w_p_sum;
    logic [QN_W-1:0] w_q_sum;
    logic [QN_W-1:0] w_t_sum;

    assign w_hold = r_vld && i_dn_stall;

    always_comb begin
        w_p_sum      = i_prod.p_num + PN_W'(HALF_ONE);
        w_q_sum      = i_prod.q_num + QN_W'(HALF_DEN);
        w_t_sum      = i_prod.t_num + QN_W'(HALF_DEN);
        n_rnd.err    = i_prod.err;
        n_rnd.grey   = i_prod.grey;
        n_rnd.sector = i_prod.sector;
        n_rnd.val    = i_prod.val;
        n_rnd.p_val  = CH_W'(w_p_sum >> CHANNEL_FRAC_BITS);
        n_rnd.q_x    = QX_W'(w_q_sum >> DEN_SHIFT);
        n_rnd.t_x    = QX_W'(w_t_sum >> DEN_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (!w_hold) begin
            r_vld <= i_up_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_hold && i_up_valid) begin
            r_rnd <= n_rnd;
        end
    end

    assign o_up_stall = w_hold;
    assign o_dn_valid = r_vld;
    assign o_rnd      = r_rnd;

endmodule

// ===== src/hsv_to_rgb_converter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core
// streaming hsv to rgb pixel converter, five register stages
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_hue, i_saturation,
//          |           |                           | i_brightness
//  out     | output    | o_out_valid / i_out_stall | o_red, o_green, o_blue,
//          |           |                           | o_range_error
//
//  one request per clock in and out while the output is not stalled; each
//  request passes in order through decode, fraction product, channel product,
//  rounding, and reciprocal divide plus channel select
//  the widest path is the 17 x 28 bit brightness product in stage 3
//  reset clears only the stage valid bits; payload registers are not reset
//  every stage holds on its own, so a stalled output lets bubbles behind it
//  fill and the input keeps taking requests until all five stages are full
//
module hsv_to_rgb_converter_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request side
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [hsv2rgb_pkg::HUE_W-1:0] i_hue,
    input  logic [hsv2rgb_pkg::CH_W-1:0]  i_saturation,
    input  logic [hsv2rgb_pkg::CH_W-1:0]  i_brightness,
    // result side
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [hsv2rgb_pkg::CH_W-1:0]  o_red,
    output logic [hsv2rgb_pkg::CH_W-1:0]  o_green,
    output logic [hsv2rgb_pkg::CH_W-1:0]  o_blue,
    output logic                          o_range_error
);
    import hsv2rgb_pkg::*;

    // stage links
    logic  w_dec_vld;
    logic  w_dec_stall;
    t_dec  w_dec;
    logic  w_prod_vld;
    logic  w_prod_stall;
    t_prod w_prod;
    logic  w_rnd_vld;
    logic  w_rnd_stall;
    t_rnd  w_rnd;

    // output stage
    logic            r_out_vld;
    logic [CH_W-1:0] r_red;
    logic [CH_W-1:0] r_green;
    logic [CH_W-1:0] r_blue;
    logic            r_err;
    logic [CH_W-1:0] n_red;
    logic [CH_W-1:0] n_green;
    logic [CH_W-1:0] n_blue;
    logic            w_out_hold;
    logic [PR_W-1:0] w_q_prod;
    logic [PR_W-1:0] w_t_prod;
    logic [CH_W-1:0] w_q;
    logic [CH_W-1:0] w_t;
    logic [CH_W-1:0] w_p;
    logic [CH_W-1:0] w_v;

    // stage 1: range check and hue sector
    hsv2rgb_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_up_valid   (i_in_valid),
        .o_up_stall   (o_in_stall),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_dn_valid   (w_dec_vld),
        .i_dn_stall   (w_dec_stall),
        .o_dec        (w_dec)
    );

    // stages 2 and 3: exact numerators of p, q and t
    hsv2rgb_product u_product (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_valid (w_dec_vld),
        .o_up_stall (w_dec_stall),
        .i_dec      (w_dec),
        .o_dn_valid (w_prod_vld),
        .i_dn_stall (w_prod_stall),
        .o_prod     (w_prod)
    );

    // stage 4: round half up, drop the power-of-two factor
    hsv2rgb_round u_round (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_valid (w_prod_vld),
        .o_up_stall (w_prod_stall),
        .i_prod     (w_prod),
        .o_dn_valid (w_rnd_vld),
        .i_dn_stall (w_rnd_stall),
        .o_rnd      (w_rnd)
    );

    // stage 5: divide q and t by the remaining factor of 15 via reciprocal
    assign w_q_prod = PR_W'(w_rnd.q_x) * PR_W'(RECIP);
    assign w_t_prod = PR_W'(w_rnd.t_x) * PR_W'(RECIP);
    assign w_q      = CH_W'(w_q_prod >> RECIP_SHIFT);
    assign w_t      = CH_W'(w_t_prod >> RECIP_SHIFT);
    assign w_p      = w_rnd.p_val;
    assign w_v      = w_rnd.val;

    // channel assignment per sector; grey and error override
    always_comb begin
        if (w_rnd.err) begin
            n_red   = '0;
            n_green = '0;
            n_blue  = '0;
        end else if (w_rnd.grey) begin
            n_red   = w_v;
            n_green = w_v;
            n_blue  = w_v;
        end else begin
            unique case (w_rnd.sector)
                SEC_RED_YEL: begin
                    n_red = w_v; n_green = w_t; n_blue = w_p;
                end
                SEC_YEL_GRN: begin
                    n_red = w_q; n_green = w_v; n_blue = w_p;
                end
                SEC_GRN_CYN: begin
                    n_red = w_p; n_green = w_v; n_blue = w_t;
                end
                SEC_CYN_BLU: begin
                    n_red = w_p; n_green = w_q; n_blue = w_v;
                end
                SEC_BLU_MAG: begin
                    n_red = w_t; n_green = w_p; n_blue = w_v;
                end
                default: begin
                    // magenta to red, and codes that never occur
                    n_red = w_v; n_green = w_p; n_blue = w_q;
                end
            endcase
        end
    end

    assign w_out_hold  = r_out_vld && i_out_stall;
    assign w_rnd_stall = w_out_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (!w_out_hold) begin
            r_out_vld <= w_rnd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_out_hold && w_rnd_vld) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
            r_err   <= w_rnd.err;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_red         = r_red;
    assign o_green       = r_green;
    assign o_blue        = r_blue;
    assign o_range_error = r_err;

endmodule

// ===== src/hsv2rgb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_checker
// port-level checks of the hsv to rgb converter, bound to the top level
// ----------------------------------------------------------------------------
module hsv2rgb_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_in_stall,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  logic [hsv2rgb_pkg::CH_W-1:0]  o_red,
    input  logic [hsv2rgb_pkg::CH_W-1:0]  o_green,
    input  logic [hsv2rgb_pkg::CH_W-1:0]  o_blue,
    input  logic                          o_range_error
);
    import hsv2rgb_pkg::*;

    // a stalled result stays offered
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result withdrawn while stalled");

    // a stalled result keeps its payload
    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_red) && $stable(o_green)
                                       && $stable(o_blue) && $stable(o_range_error))
        else $error("result payload changed while stalled");

    // input backpressure only when the whole pipe is full behind a stalled output
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with room in the pipeline");

    // an error result carries black
    a_error_is_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_range_error |-> o_red == '0 && o_green == '0 && o_blue == '0)
        else $error("error result with nonzero channels");

    // no channel exceeds full scale
    a_channel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_red <= CH_W'(ONE) && o_green <= CH_W'(ONE)
                        && o_blue <= CH_W'(ONE))
        else $error("channel above full scale");

endmodule

bind hsv_to_rgb_converter_core hsv2rgb_checker u_hsv2rgb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_red         (o_red),
    .o_green       (o_green),
    .o_blue        (o_blue),
    .o_range_error (o_range_error)
);
